// ===== hw/rtl/srpf_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srpf_pkg: shared types and constants for the stereogram row pixel filler
// Transaction payloads, register indexes, fill modes and pipeline control.
// ----------------------------------------------------------------------------
package srpf_pkg;

   localparam int LINK_W      = 10;
   localparam int RAND_W      = 8;
   localparam int COLOR_W     = 32;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 32;
   localparam int MODE_W      = 2;
   localparam int DOT_W       = 5;
   localparam int ROW_W       = 11;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_FILL_MODE      = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_DENSITY        = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_COPY_DENSITY   = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_AUTOMATON_RULE = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_DOT_SIZE       = 3'd4;
   localparam logic [CSR_INDEX_W-1:0] CSR_FIRST_COLOR    = 3'd5;
   localparam logic [CSR_INDEX_W-1:0] CSR_SECOND_COLOR   = 3'd6;
   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_WIDTH      = 3'd7;

   // register reset values
   localparam logic [MODE_W-1:0]  FILL_MODE_RESET      = 2'd1;
   localparam logic [RAND_W-1:0]  DENSITY_RESET        = 8'd128;
   localparam logic [RAND_W-1:0]  COPY_DENSITY_RESET   = 8'd0;
   localparam logic [RAND_W-1:0]  AUTOMATON_RULE_RESET = 8'd90;
   localparam logic [DOT_W-1:0]   DOT_SIZE_RESET       = 5'd1;
   localparam logic [COLOR_W-1:0] FIRST_COLOR_RESET    = 32'h0000_0000;
   localparam logic [COLOR_W-1:0] SECOND_COLOR_RESET   = 32'hffff_ffff;
   localparam logic [ROW_W-1:0]   ROW_WIDTH_RESET      = 11'd1024;

   // fill modes; code zero runs as random with vertical copy
   localparam logic [MODE_W-1:0] FILL_COPY      = 2'd1;
   localparam logic [MODE_W-1:0] FILL_RANDOM    = 2'd2;
   localparam logic [MODE_W-1:0] FILL_AUTOMATON = 2'd3;

   typedef struct packed {
      logic [LINK_W-1:0] link_target;
      logic [RAND_W-1:0] random_copy;
      logic [RAND_W-1:0] random_pick;
   } req_type;

   typedef struct packed {
      logic [COLOR_W-1:0] pixel_color;
      logic               row_end;
      logic               link_error;
   } rsp_type;

   // where the colour choice of a pixel comes from
   typedef enum logic [1:0] {
      SRC_RANDOM,
      SRC_CURRENT,
      SRC_PREVIOUS,
      SRC_RULE
   } src_type;

   // one row-buffer word: the column's latest bit and the bit it replaced
   typedef struct packed {
      logic prior;
      logic latest;
   } row_word_type;

   // position flags of the pixel at the head of the stream
   typedef struct packed {
      logic first_row;
      logic row_phase_nz;
      logic col_phase_nz;
      logic last;
   } pos_type;

   // control carried by a pixel from issue to the pick stage
   typedef struct packed {
      src_type           src;
      logic              rand_bit;
      logic              ca_en;
      logic [RAND_W-1:0] rule;
      logic              last;
      logic              err;
      logic              prev_old;
      logic              left_old;
   } s1_ctrl_type;

endpackage
`default_nettype wire

// ===== hw/rtl/srpf_row_ram.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srpf_row_ram: row buffer with one write and two read ports
// Read data is registered; a read of the address written in the same cycle
// returns the new word.
// ----------------------------------------------------------------------------
module srpf_row_ram #(
   parameter int DEPTH = 1024,
   parameter int AW    = $clog2(DEPTH),
   parameter int WIDTH = 1
) (
   input  wire logic             clock,
   input  wire logic             wr_en,
   input  wire logic [AW-1:0]    wr_addr,
   input  wire logic [WIDTH-1:0] wr_data,
   input  wire logic             rd_en,
   input  wire logic [AW-1:0]    rd_addr_a,
   input  wire logic [AW-1:0]    rd_addr_b,
   output logic [WIDTH-1:0]      rd_data_a,
   output logic [WIDTH-1:0]      rd_data_b
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_a_ff;
   logic [WIDTH-1:0] rd_b_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_a_ff <= (wr_en && (wr_addr == rd_addr_a)) ? wr_data : mem[rd_addr_a];
         rd_b_ff <= (wr_en && (wr_addr == rd_addr_b)) ? wr_data : mem[rd_addr_b];
      end
   end

   assign rd_data_a = rd_a_ff;
   assign rd_data_b = rd_b_ff;

endmodule
`default_nettype wire

// ===== hw/rtl/srpf_position.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srpf_position: column, block phase and row tracking
// Advances once per accepted pixel; restarts the column at each row end.
// ----------------------------------------------------------------------------
module srpf_position #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_DOT   = 16,
   parameter int CW        = $clog2(MAX_WIDTH),
   parameter int WW        = $clog2(MAX_WIDTH + 1),
   parameter int DW        = $clog2(MAX_DOT + 1)
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire logic                        advance,
   input  wire logic [srpf_pkg::DOT_W-1:0]  dot_size,
   input  wire logic [srpf_pkg::ROW_W-1:0]  row_width,
   output logic [CW-1:0]                    x,
   output logic [CW-1:0]                    block,
   output logic [DW-1:0]                    ds,
   output logic [WW-1:0]                    w,
   output srpf_pkg::pos_type                pos
);
   import srpf_pkg::*;

   localparam int PW = (MAX_DOT > 1) ? $clog2(MAX_DOT) : 1;

   logic [CW-1:0] column_ff;
   logic [PW-1:0] column_phase_ff;
   logic [PW-1:0] row_phase_ff;
   logic          first_row_ff;

   logic [PW-1:0] cph;
   logic [PW-1:0] column_phase_in;
   logic [PW-1:0] row_phase_in;
   logic          last;

   always_comb begin
      // clamp dot size and row width into range
      if (dot_size == '0) begin
         ds = DW'(1);
      end else if (32'(dot_size) > MAX_DOT) begin
         ds = DW'(MAX_DOT);
      end else begin
         ds = DW'(dot_size);
      end
      if (row_width == '0) begin
         w = WW'(1);
      end else if (32'(row_width) > MAX_WIDTH) begin
         w = WW'(MAX_WIDTH);
      end else begin
         w = WW'(row_width);
      end

      x     = column_ff;
      cph   = (32'(column_phase_ff) <= 32'(column_ff)) ? column_phase_ff : '0;
      block = column_ff - CW'(cph);
      last  = (32'(column_ff) + 32'd1) >= 32'(w);

      column_phase_in = ((32'(cph) + 32'd1) >= 32'(ds)) ? '0 : cph + PW'(1);
      row_phase_in    = ((32'(row_phase_ff) + 32'd1) >= 32'(ds)) ? '0
                                                                 : row_phase_ff + PW'(1);

      pos.first_row    = first_row_ff;
      pos.row_phase_nz = (row_phase_ff != '0);
      pos.col_phase_nz = (cph != '0);
      pos.last         = last;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         column_ff       <= '0;
         column_phase_ff <= '0;
         row_phase_ff    <= '0;
         first_row_ff    <= 1'b1;
      end else if (advance) begin
         if (last) begin
            // row done: restart column, step row phase
            column_ff       <= '0;
            column_phase_ff <= '0;
            row_phase_ff    <= row_phase_in;
            first_row_ff    <= 1'b0;
         end else begin
            column_ff       <= column_ff + CW'(1);
            column_phase_ff <= column_phase_in;
         end
      end
   end

endmodule
`default_nettype wire

// ===== hw/rtl/srpf_issue.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srpf_issue: per-pixel source decision and row buffer addressing
// Picks where the pixel's colour comes from and which buffer words to fetch.
// ----------------------------------------------------------------------------
module srpf_issue #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_DOT   = 16,
   parameter int CW        = $clog2(MAX_WIDTH),
   parameter int WW        = $clog2(MAX_WIDTH + 1),
   parameter int DW        = $clog2(MAX_DOT + 1)
) (
   input  wire logic [CW-1:0]                   x,
   input  wire logic [CW-1:0]                   block,
   input  wire logic [DW-1:0]                   ds,
   input  wire logic [WW-1:0]                   w,
   input  wire srpf_pkg::pos_type               pos,
   input  wire srpf_pkg::req_type               req,
   input  wire logic [srpf_pkg::MODE_W-1:0]     fill_mode,
   input  wire logic [srpf_pkg::RAND_W-1:0]     density,
   input  wire logic [srpf_pkg::RAND_W-1:0]     copy_density,
   input  wire logic [srpf_pkg::RAND_W-1:0]     automaton_rule,
   input  wire logic [srpf_pkg::COLOR_W-1:0]    first_color,
   input  wire logic [srpf_pkg::COLOR_W-1:0]    second_color,
   output srpf_pkg::s1_ctrl_type                ctrl,
   output logic [CW-1:0]                        cur_addr,
   output logic [CW-1:0]                        prev_addr,
   output logic [CW-1:0]                        left_addr
);
   import srpf_pkg::*;

   logic          linked;
   logic          copy_hit;
   logic          above_block;
   logic [CW-1:0] right_addr;

   always_comb begin
      linked      = 32'(req.link_target) < 32'(x);
      copy_hit    = (copy_density != '0) && !pos.first_row
                    && (req.random_copy < copy_density);
      above_block = !pos.first_row && pos.row_phase_nz;

      ctrl.rand_bit = !(req.random_pick > density);
      ctrl.ca_en    = (second_color != first_color);
      ctrl.rule     = automaton_rule;
      ctrl.last     = pos.last;
      ctrl.err      = 32'(req.link_target) > 32'(x);
      ctrl.src      = SRC_RANDOM;

      cur_addr  = block;
      prev_addr = x;
      left_addr = (32'(x) >= 32'(ds)) ? x - CW'(ds) : '0;
      right_addr = ((32'(x) + 32'(ds)) < 32'(w)) ? CW'(32'(x) + 32'(ds))
                                                 : CW'(32'(w) - 32'd1);

      if (linked) begin
         ctrl.src = SRC_CURRENT;
         cur_addr = CW'(req.link_target);
      end else begin
         unique case (fill_mode)
            FILL_RANDOM: begin
               priority if (pos.col_phase_nz) begin
                  ctrl.src = SRC_CURRENT;
               end else if (above_block) begin
                  ctrl.src  = SRC_PREVIOUS;
                  prev_addr = block;
               end else begin
                  ctrl.src = SRC_RANDOM;
               end
            end
            FILL_AUTOMATON: begin
               priority if (pos.col_phase_nz) begin
                  ctrl.src = SRC_CURRENT;
                  cur_addr = (x == '0) ? '0 : x - CW'(1);
               end else if (pos.first_row) begin
                  ctrl.src = SRC_RANDOM;
               end else if (pos.row_phase_nz) begin
                  ctrl.src = SRC_PREVIOUS;
               end else begin
                  // center comes from the own-column read; fetch the right cell here
                  ctrl.src  = SRC_RULE;
                  prev_addr = right_addr;
               end
            end
            default: begin
               // random with vertical copy
               priority if (above_block) begin
                  ctrl.src  = SRC_PREVIOUS;
                  prev_addr = block;
               end else if (pos.col_phase_nz) begin
                  ctrl.src = SRC_CURRENT;
               end else if (copy_hit) begin
                  ctrl.src = SRC_PREVIOUS;
               end else begin
                  ctrl.src = SRC_RANDOM;
               end
            end
         endcase
      end

      // columns left of x already hold this row's bits
      ctrl.left_old = (left_addr < x);
      ctrl.prev_old = (prev_addr < x);
   end

endmodule
`default_nettype wire

// ===== hw/rtl/srpf_pick.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// srpf_pick: final colour choice of one pixel
// Selects between fetched row bits, the random draw and the automaton rule.
// ----------------------------------------------------------------------------
module srpf_pick (
   input  wire srpf_pkg::s1_ctrl_type  ctrl,
   input  wire srpf_pkg::row_word_type cur_word,
   input  wire srpf_pkg::row_word_type center_word,
   input  wire srpf_pkg::row_word_type left_word,
   input  wire srpf_pkg::row_word_type far_word,
   output logic                        choice
);
   import srpf_pkg::*;

   logic       left_bit;
   logic       far_bit;
   logic [2:0] rule_idx;

   always_comb begin
      // row above: take the replaced bit where this row already wrote
      left_bit = ctrl.left_old ? left_word.prior : left_word.latest;
      far_bit  = ctrl.prev_old ? far_word.prior : far_word.latest;
      rule_idx = {far_bit & ctrl.ca_en, center_word.latest & ctrl.ca_en,
                  left_bit & ctrl.ca_en};
      unique case (ctrl.src)
         SRC_RANDOM:   choice = ctrl.rand_bit;
         SRC_CURRENT:  choice = cur_word.latest;
         SRC_PREVIOUS: choice = far_bit;
         SRC_RULE:     choice = ctrl.rule[rule_idx];
         default:      choice = ctrl.rand_bit;
      endcase
   end

endmodule
`default_nettype wire

// ===== hw/rtl/stereogram_row_pixel_filler.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// stereogram_row_pixel_filler: random-dot stereogram row filler
// Usage:
//   req_* carries one pixel transaction (link target, two random bytes);
//   rsp_* returns its colour word with row-end and link-error flags.
//   csr_* writes the eight configuration registers; csr_ready is always high.
//   Write configuration only while no pixel is in flight.
// Pipeline: an accepted pixel passes the row-buffer read and pick-stage
//   registers, then the result register, before it shows on rsp_valid.
// Throughput: one pixel per cycle while the result is not stalled; two copies
//   of the row buffer give four read ports, so every fetch a pixel may need is issued in its accept cycle.
// Reset: registers return to defaults, position returns to column zero of a
//   first row. The row buffers are not cleared; they are filled by pixels.
// Stall: a stalled result holds in the output register; one more pixel is
//   still taken into the pick stage, after which req_stall rises.
// ----------------------------------------------------------------------------
module stereogram_row_pixel_filler #(
   parameter int MAX_WIDTH = 1024,
   parameter int MAX_DOT   = 16
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   // pixel request channel
   input  wire logic                              req_valid,
   output logic                                   req_stall,
   input  wire srpf_pkg::req_type                 req_data,
   // pixel result channel
   output logic                                   rsp_valid,
   input  wire logic                              rsp_stall,
   output srpf_pkg::rsp_type                      rsp_data,
   // configuration write channel
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [srpf_pkg::CSR_INDEX_W-1:0]  csr_index,
   input  wire logic [srpf_pkg::CSR_DATA_W-1:0]   csr_data
);
   import srpf_pkg::*;

   localparam int CW = $clog2(MAX_WIDTH);
   localparam int WW = $clog2(MAX_WIDTH + 1);
   localparam int DW = $clog2(MAX_DOT + 1);

   // configuration registers
   logic [MODE_W-1:0]  fill_mode_ff;
   logic [RAND_W-1:0]  density_ff;
   logic [RAND_W-1:0]  copy_density_ff;
   logic [RAND_W-1:0]  automaton_rule_ff;
   logic [DOT_W-1:0]   dot_size_ff;
   logic [COLOR_W-1:0] first_color_ff;
   logic [COLOR_W-1:0] second_color_ff;
   logic [ROW_W-1:0]   row_width_ff;

   // handshake
   logic accept;
   logic out_free;
   logic s1_move;

   // position and issue
   logic [CW-1:0] x;
   logic [CW-1:0] block;
   logic [DW-1:0] ds;
   logic [WW-1:0] w;
   pos_type       pos;
   s1_ctrl_type   issue_ctrl;
   logic [CW-1:0] cur_addr;
   logic [CW-1:0] prev_addr;
   logic [CW-1:0] left_addr;

   // pick stage
   logic          s1_valid_ff;
   s1_ctrl_type   s1_ctrl_ff;
   logic [CW-1:0] s1_x_ff;
   row_word_type  cur_word;
   row_word_type  center_word;
   row_word_type  left_word;
   row_word_type  far_word;
   row_word_type  wr_word;
   logic          choice;

   // result register
   logic    rsp_valid_ff;
   rsp_type rsp_data_ff;

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         fill_mode_ff      <= FILL_MODE_RESET;
         density_ff        <= DENSITY_RESET;
         copy_density_ff   <= COPY_DENSITY_RESET;
         automaton_rule_ff <= AUTOMATON_RULE_RESET;
         dot_size_ff       <= DOT_SIZE_RESET;
         first_color_ff    <= FIRST_COLOR_RESET;
         second_color_ff   <= SECOND_COLOR_RESET;
         row_width_ff      <= ROW_WIDTH_RESET;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            CSR_FILL_MODE:      fill_mode_ff      <= csr_data[MODE_W-1:0];
            CSR_DENSITY:        density_ff        <= csr_data[RAND_W-1:0];
            CSR_COPY_DENSITY:   copy_density_ff   <= csr_data[RAND_W-1:0];
            CSR_AUTOMATON_RULE: automaton_rule_ff <= csr_data[RAND_W-1:0];
            CSR_DOT_SIZE:       dot_size_ff       <= csr_data[DOT_W-1:0];
            CSR_FIRST_COLOR:    first_color_ff    <= csr_data[COLOR_W-1:0];
            CSR_SECOND_COLOR:   second_color_ff   <= csr_data[COLOR_W-1:0];
            CSR_ROW_WIDTH:      row_width_ff      <= csr_data[ROW_W-1:0];
            default:            fill_mode_ff      <= fill_mode_ff;
         endcase
      end
   end

   // The pick stage drains whenever the result register is empty or being
   // taken; a new pixel enters whenever the pick stage is empty or draining.
   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign s1_move   = s1_valid_ff && out_free;
   assign req_stall = s1_valid_ff && !out_free;
   assign accept    = req_valid && !req_stall;

   // Position state advances on accept; nothing in it depends on pixel data.
   srpf_position #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_DOT   (MAX_DOT),
      .CW        (CW),
      .WW        (WW),
      .DW        (DW)
   ) u_position (
      .clock     (clock),
      .reset     (reset),
      .advance   (accept),
      .dot_size  (dot_size_ff),
      .row_width (row_width_ff),
      .x         (x),
      .block     (block),
      .ds        (ds),
      .w         (w),
      .pos       (pos)
   );

   srpf_issue #(
      .MAX_WIDTH (MAX_WIDTH),
      .MAX_DOT   (MAX_DOT),
      .CW        (CW),
      .WW        (WW),
      .DW        (DW)
   ) u_issue (
      .x              (x),
      .block          (block),
      .ds             (ds),
      .w              (w),
      .pos            (pos),
      .req            (req_data),
      .fill_mode      (fill_mode_ff),
      .density        (density_ff),
      .copy_density   (copy_density_ff),
      .automaton_rule (automaton_rule_ff),
      .first_color    (first_color_ff),
      .second_color   (second_color_ff),
      .ctrl           (issue_ctrl),
      .cur_addr       (cur_addr),
      .prev_addr      (prev_addr),
      .left_addr      (left_addr)
   );

   // Each row-buffer word keeps a column's latest bit and the bit that it
   // replaced. Columns left of the pixel were rewritten in this row, so the
   // row above reads the replaced bit there and the latest bit elsewhere.
   // The own-column read supplies the bit to keep as replaced when the pick
   // stage writes the pixel; the RAM forwards that word to a read issued in
   // the same cycle. Two identical copies give four read ports.
   assign wr_word = {center_word.latest, choice};

   srpf_row_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW),
      .WIDTH ($bits(row_word_type))
   ) u_ram_near (
      .clock     (clock),
      .wr_en     (s1_move),
      .wr_addr   (s1_x_ff),
      .wr_data   (wr_word),
      .rd_en     (accept),
      .rd_addr_a (cur_addr),
      .rd_addr_b (x),
      .rd_data_a (cur_word),
      .rd_data_b (center_word)
   );

   srpf_row_ram #(
      .DEPTH (MAX_WIDTH),
      .AW    (CW),
      .WIDTH ($bits(row_word_type))
   ) u_ram_side (
      .clock     (clock),
      .wr_en     (s1_move),
      .wr_addr   (s1_x_ff),
      .wr_data   (wr_word),
      .rd_en     (accept),
      .rd_addr_a (left_addr),
      .rd_addr_b (prev_addr),
      .rd_data_a (left_word),
      .rd_data_b (far_word)
   );

   // pick stage register: hold while the result register is stalled
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
      end else if (accept) begin
         s1_valid_ff <= 1'b1;
      end else if (s1_move) begin
         s1_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (accept) begin
         s1_ctrl_ff <= issue_ctrl;
         s1_x_ff    <= x;
      end
   end

   srpf_pick u_pick (
      .ctrl        (s1_ctrl_ff),
      .cur_word    (cur_word),
      .center_word (center_word),
      .left_word   (left_word),
      .far_word    (far_word),
      .choice      (choice)
   );

   // result register: load on drain, drop once taken
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (s1_move) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (s1_move) begin
         rsp_data_ff.pixel_color <= choice ? second_color_ff : first_color_ff;
         rsp_data_ff.row_end     <= s1_ctrl_ff.last;
         rsp_data_ff.link_error  <= s1_ctrl_ff.err;
      end
   end

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule
`default_nettype wire
